// ===== rtl/core/bol_pkg.sv =====
// Package for the bounded ordered list: sizes, codes, transfer structs and
// the controller/datapath command and status groups. No dependencies.
package bol_pkg;

	// Sizing
	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_DELETE     = 2'd2,
		OP_READ_ALL   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BADIX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_EXEC  = 2'd1,
		S_SHIFT = 2'd2,
		S_READ  = 2'd3
	} state_t;

	// Input transfer
	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  value;
		logic        [POS_W-1:0]   position;
	} in_item_t;

	// Result transfer
	typedef struct packed {
		logic signed [DATA_W-1:0]  data;
		status_t                   status;
		logic        [COUNT_W-1:0] element_count;
		logic                      is_last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    wr_back;
		logic    wr_front;
		logic    dec_count;
		logic    shift_start;
		logic    shift_step;
		logic    read_start;
		logic    read_step;
		logic    emit;
		logic    emit_data;
		status_t emit_status;
	} ctrl_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic pos_bad;
		logic pos_last;
		logic shift_end;
		logic read_last;
	} stat_t;

	// Physical slot of a logical position, relative to the head slot.
	// lidx may equal CAPACITY, so the sum stays below twice CAPACITY.
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
		input logic [CNT_W-1:0] lidx);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ===== rtl/core/bol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. No dependencies.
module bol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/bol_ctrl.sv =====
// Controller for the bounded ordered list: sequences push, delete-with-shift
// and read-out. Depends on bol_pkg.
module bol_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bol_pkg::stat_t stat,
	output bol_pkg::ctrl_t ctrl,
	output logic           busy
);
	import bol_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
				if (stat.op == OP_DELETE && !stat.empty && !stat.pos_bad && !stat.pos_last)
					state_nxt = S_SHIFT;
				if (stat.op == OP_READ_ALL && !stat.empty)
					state_nxt = S_READ;
			end
			S_SHIFT: begin
				if (stat.shift_end) state_nxt = S_IDLE;
			end
			S_READ: begin
				if (stat.read_last) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl             = '0;
		ctrl.emit_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				ctrl.load = start;
			end
			S_EXEC: begin
				case (stat.op)
					OP_PUSH_BACK, OP_PUSH_FRONT: begin
						ctrl.emit = 1'b1;
						if (stat.full) begin
							ctrl.emit_status = ST_FULL;
						end else begin
							ctrl.wr_back  = (stat.op == OP_PUSH_BACK);
							ctrl.wr_front = (stat.op == OP_PUSH_FRONT);
						end
					end
					OP_DELETE: begin
						if (stat.empty) begin
							ctrl.emit        = 1'b1;
							ctrl.emit_status = ST_EMPTY;
						end else if (stat.pos_bad) begin
							ctrl.emit        = 1'b1;
							ctrl.emit_status = ST_BADIX;
						end else if (stat.pos_last) begin
							ctrl.emit      = 1'b1;
							ctrl.dec_count = 1'b1;
						end else begin
							ctrl.shift_start = 1'b1;
						end
					end
					OP_READ_ALL: begin
						if (stat.empty) begin
							ctrl.emit        = 1'b1;
							ctrl.emit_status = ST_EMPTY;
						end else begin
							ctrl.read_start = 1'b1;
						end
					end
					default: ctrl.emit = 1'b0;
				endcase
			end
			S_SHIFT: begin
				ctrl.shift_step = 1'b1;
				if (stat.shift_end) begin
					ctrl.dec_count = 1'b1;
					ctrl.emit      = 1'b1;
				end
			end
			S_READ: begin
				ctrl.read_step = 1'b1;
				ctrl.emit      = 1'b1;
				ctrl.emit_data = 1'b1;
			end
			default: ctrl.emit = 1'b0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/core/bol_dpath.sv =====
// Datapath for the bounded ordered list: circular element store, head and
// count registers, walk index and result register. Depends on bol_pkg, bol_ram.
module bol_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  bol_pkg::in_item_t  item,
	input  bol_pkg::ctrl_t     ctrl,
	output bol_pkg::stat_t     stat,
	output bol_pkg::out_item_t result,
	output logic               done
);
	import bol_pkg::*;

	in_item_t                 item_q;
	logic     [ADDR_W-1:0]    head_q;
	logic     [CNT_W-1:0]     count_q;
	logic     [CNT_W-1:0]     idx_q;
	out_item_t                res_q;
	logic                     done_q;

	logic                     we;
	logic     [ADDR_W-1:0]    waddr;
	logic     [DATA_W-1:0]    wdata;
	logic     [ADDR_W-1:0]    raddr;
	logic     [DATA_W-1:0]    rdata;
	logic     [ADDR_W-1:0]    head_dec;
	logic     [CNT_W-1:0]     count_nxt;

	assign head_dec = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : head_q - 1'b1;

	// Element count after the current operation
	always_comb begin
		count_nxt = count_q;
		if (ctrl.wr_back || ctrl.wr_front) count_nxt = count_q + 1'b1;
		if (ctrl.dec_count)                count_nxt = count_q - 1'b1;
	end

	// Status to the controller
	always_comb begin
		stat.op        = item_q.op;
		stat.empty     = (count_q == '0);
		stat.full      = (count_q == CNT_W'(CAPACITY));
		stat.pos_bad   = (item_q.position == '0) || (item_q.position > POS_W'(count_q));
		stat.pos_last  = (item_q.position == POS_W'(count_q));
		stat.shift_end = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2)) == (CNT_W+1)'(count_q);
		stat.read_last = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(count_q);
	end

	// Store addressing: pushes and shift write-back, prefetch for shift and read-out
	always_comb begin
		we    = ctrl.wr_back || ctrl.wr_front || ctrl.shift_step;
		waddr = phys(head_q, idx_q);
		wdata = rdata;
		if (ctrl.wr_back) begin
			waddr = phys(head_q, count_q);
			wdata = item_q.value;
		end else if (ctrl.wr_front) begin
			waddr = head_dec;
			wdata = item_q.value;
		end
		raddr = head_q;
		if (ctrl.shift_start) raddr = phys(head_q, item_q.position[CNT_W-1:0]);
		if (ctrl.shift_step)  raddr = phys(head_q, idx_q + CNT_W'(2));
		if (ctrl.read_step)   raddr = phys(head_q, idx_q + CNT_W'(1));
	end

	bol_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= ctrl.emit;
			if (ctrl.wr_front)    head_q <= head_dec;
			if (ctrl.shift_start) idx_q  <= CNT_W'(item_q.position - 1'b1);
			if (ctrl.read_start)  idx_q  <= '0;
			if (ctrl.shift_step || ctrl.read_step) idx_q <= idx_q + 1'b1;
		end
	end

	// Latched item and result register
	always_ff @(posedge clk) begin
		if (ctrl.load) item_q <= item;
		if (ctrl.emit) begin
			res_q.data          <= ctrl.emit_data ? rdata : '0;
			res_q.status        <= ctrl.emit_status;
			res_q.element_count <= COUNT_W'(count_nxt);
			res_q.is_last       <= ctrl.emit_data ? stat.read_last : 1'b1;
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

// ===== rtl/core/bounded_ordered_list.sv =====
// Bounded ordered list of signed 32-bit values, top level.
// Accepts one operation per transfer: push back, push front, delete at a
// 1-based position, or read out all elements front to back.
// Channels: item is taken at a rising edge where start is high and busy is
// low. Each result appears on result for one cycle with done high; the
// receiver takes it at the edge that ends that cycle and cannot stall.
// A push, a failed delete, a delete of the back element and an
// empty read-out give their single result, emitted in the execute state.
// A delete at position p of n elements walks the store, moving n-p elements
// one slot forward, one per cycle through the store's single write port,
// and gives its result when the walk ends.
// A read-out of n elements gives n results in consecutive cycles, one per
// cycle as the registered read port streams the store.
// busy falls in the cycle of the last result, so the next item may be taken
// while that result is shown.
// Reset empties the list at once; the store itself is not cleared.
// Depends on bol_pkg, bol_ctrl, bol_dpath, bol_ram.
module bounded_ordered_list (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bol_pkg::in_item_t  item,
	output bol_pkg::out_item_t result,
	output logic               done
);
	import bol_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	bol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	bol_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctrl   (ctrl),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

`ifndef SYNTHESIS
	// Held count never goes beyond capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.element_count <= COUNT_W'(CAPACITY)))
		else $error("element count above capacity");

	// Status results always close their item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> result.is_last)
		else $error("status result without last mark");

	// Read-out results follow each other without gaps
	a_readout_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.is_last) |=> done)
		else $error("gap in read-out results");

	// A transfer keeps the block busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after transfer");
`endif

endmodule
